[rtl/core/utf8gs_pkg.sv]
package utf8gs_pkg;

   localparam logic [20:0] REPLACEMENT = 21'h00FFFD;
   localparam logic [20:0] JOINER      = 21'h00200D;
   localparam logic [20:0] RI_FIRST    = 21'h1F1E6;
   localparam logic [20:0] RI_LAST     = 21'h1F1FF;
   localparam int          EXTEND_RANGES = 13;

   localparam logic [20:0] EXTEND_LO [EXTEND_RANGES] = '{
      21'h00300, 21'h01AB0, 21'h01DC0, 21'h0FE20, 21'h020D0, 21'h00483, 21'h00591,
      21'h00610, 21'h0064B, 21'h00E31, 21'h0FE00, 21'hE0100, 21'h1F3FB
   };
   localparam logic [20:0] EXTEND_HI [EXTEND_RANGES] = '{
      21'h0036F, 21'h01AFF, 21'h01DFF, 21'h0FE2F, 21'h020F0, 21'h00489, 21'h005BD,
      21'h0061A, 21'h0065F, 21'h00E3A, 21'h0FE0F, 21'hE01EF, 21'h1F3FF
   };

   typedef struct packed {
      logic [7:0] text_byte;
      logic       final_byte;
   } req_payload_type;

   typedef struct packed {
      logic [20:0] code_value;
      logic [2:0]  byte_count;
      logic        replaced;
      logic        starts_character;
      logic        text_end;
      logic        run_last;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      ACT_EMIT,
      ACT_REPLACE,
      ACT_WAIT
   } action_type;

   typedef enum logic [1:0] {
      MODE_START,
      MODE_NORMAL,
      MODE_RI_OPEN,
      MODE_CLOSED
   } cluster_mode_type;

   typedef struct packed {
      action_type  action;
      logic [20:0] value;
      logic [2:0]  length;
   } decode_type;

   // one decoded item, or a bare step-end mark when a tail waits for more bytes
   typedef struct packed {
      logic        has_result;
      logic        step_end;
      logic        text_fin;
      logic [20:0] code_value;
      logic [2:0]  byte_count;
      logic        replaced;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } queue_port_type;

   typedef struct packed {
      logic replaced;
      logic step_end;
      logic text_fin;
   } held_flags_type;

   function automatic logic is_cont(input logic [7:0] b);
      return b[7:6] == 2'b10;
   endfunction

   function automatic logic is_ri(input logic [20:0] c);
      return (c >= RI_FIRST) && (c <= RI_LAST);
   endfunction

   function automatic logic is_extend(input logic [20:0] c);
      logic hit;
      hit = 1'b0;
      for (int i = 0; i < EXTEND_RANGES; i++) begin
         if (c >= EXTEND_LO[i] && c <= EXTEND_HI[i]) hit = 1'b1;
      end
      return hit;
   endfunction

   // decode the sequence that starts at win[0]; avail bytes are present
   function automatic decode_type utf8gs_decode(input logic [3:0][7:0] win,
                                                input logic [2:0] avail,
                                                input logic fin);
      logic [7:0] lead;
      logic [7:0] lo;
      logic [7:0] hi;
      logic [2:0] len;
      logic       bad;
      decode_type d;
      lead = win[0];
      lo   = 8'h80;
      hi   = 8'hBF;
      len  = 3'd0;
      if (lead >= 8'hC2 && lead <= 8'hDF) len = 3'd2;
      else if (lead >= 8'hE0 && lead <= 8'hEF) len = 3'd3;
      else if (lead >= 8'hF0 && lead <= 8'hF4) len = 3'd4;
      if (lead == 8'hE0) lo = 8'hA0;
      if (lead == 8'hED) hi = 8'h9F;
      if (lead == 8'hF0) lo = 8'h90;
      if (lead == 8'hF4) hi = 8'h8F;
      bad = (len >= 3'd2 && avail >= 3'd2 && (win[1] < lo || win[1] > hi)) ||
            (len >= 3'd3 && avail >= 3'd3 && !is_cont(win[2])) ||
            (len == 3'd4 && avail == 3'd4 && !is_cont(win[3]));
      case (len)
         3'd2:    d.value = {10'b0, lead[4:0], win[1][5:0]};
         3'd3:    d.value = {5'b0, lead[3:0], win[1][5:0], win[2][5:0]};
         3'd4:    d.value = {lead[2:0], win[1][5:0], win[2][5:0], win[3][5:0]};
         default: d.value = {13'b0, lead};
      endcase
      d.length = len;
      if (lead < 8'h80) begin
         d.action = ACT_EMIT;
         d.length = 3'd1;
      end else if (len == 3'd0 || bad) begin
         d.action = ACT_REPLACE;
      end else if (avail < len) begin
         d.action = fin ? ACT_REPLACE : ACT_WAIT;
      end else begin
         d.action = ACT_EMIT;
      end
      return d;
   endfunction

endpackage

[rtl/core/utf8gs_if.sv]
interface utf8gs_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

[rtl/core/utf8_decode_grapheme_split_core.sv]
// channel   dir  payload                                                  handshake
// req_bus   in   text_byte[7:0], final_byte                               valid/ready
// rsp_bus   out  code_value[20:0], byte_count[2:0], replaced,             valid/ready
//                starts_character, text_end, run_last
//
// a request is taken in, then the single decode unit in the front end pushes one entry for each
// codepoint it completes or fails, plus a bare step-end mark when a tail waits for more bytes;
// a full queue stalls it, and no new request is taken until the last one is fully decoded
// results leave through a held stage and an output register, at most one per cycle
// synchronous reset clears the counts, the queue, the held codepoint and segmentation state
// either side may stall; the queue between front and back absorbs the difference
module utf8_decode_grapheme_split_core
   import utf8gs_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic     clock,
   input  logic     reset,
   utf8gs_if.sink   req_bus,
   utf8gs_if.source rsp_bus
);

   queue_port_type push;
   queue_port_type head;
   logic           q_full;
   logic           pop;

   utf8gs_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .q_full  (q_full),
      .push    (push)
   );

   utf8gs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (q_full),
      .head  (head),
      .pop   (pop)
   );

   utf8gs_back u_back (
      .clock   (clock),
      .reset   (reset),
      .head    (head),
      .pop     (pop),
      .rsp_bus (rsp_bus)
   );

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push.valid && q_full))
      else $error("decode entry pushed into a full queue");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.data.text_end |-> rsp_bus.data.run_last)
      else $error("end of text not on the last result of its request");

   a_replaced_form: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.data.replaced |->
         rsp_bus.data.code_value == REPLACEMENT && rsp_bus.data.byte_count == 3'd1)
      else $error("replacement result with wrong value or length");

   a_pop_has_data: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("back end popped an empty queue");
`endif

endmodule

[rtl/core/utf8gs_front.sv]
module utf8gs_front
   import utf8gs_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   utf8gs_if.sink         req_bus,
   input  logic           q_full,
   output queue_port_type push
);

   logic [3:0][7:0] win_ff, win_in;
   logic [2:0]      fill_ff, fill_in;
   logic            fin_ff, fin_in;
   logic            busy_ff, busy_in;
   decode_type      dec;
   logic [2:0]      cons;

   assign req_bus.ready = !busy_ff;

   always_comb begin
      dec  = utf8gs_decode(win_ff, fill_ff, fin_ff);
      cons = (dec.action == ACT_EMIT) ? dec.length : 3'd1;
   end

   always_comb begin
      win_in  = win_ff;
      fill_in = fill_ff;
      fin_in  = fin_ff;
      busy_in = busy_ff;
      push.valid            = 1'b0;
      push.entry.has_result = 1'b0;
      push.entry.step_end   = 1'b0;
      push.entry.text_fin   = 1'b0;
      push.entry.code_value = (dec.action == ACT_EMIT) ? dec.value : REPLACEMENT;
      push.entry.byte_count = cons;
      push.entry.replaced   = dec.action == ACT_REPLACE;
      if (req_bus.valid && !busy_ff) begin
         // the buffer never holds more than three bytes between requests
         win_in[fill_ff[1:0]] = req_bus.data.text_byte;
         fill_in = fill_ff + 3'd1;
         fin_in  = req_bus.data.final_byte;
         busy_in = 1'b1;
      end else if (busy_ff && !q_full) begin
         push.valid = 1'b1;
         if (dec.action == ACT_WAIT) begin
            // incomplete tail stays in the window as the carried buffer
            push.entry.step_end = 1'b1;
            busy_in = 1'b0;
         end else begin
            push.entry.has_result = 1'b1;
            push.entry.step_end   = fill_ff == cons;
            push.entry.text_fin   = fin_ff && (fill_ff == cons);
            fill_in = fill_ff - cons;
            win_in  = win_ff >> {cons, 3'b000};
            busy_in = fill_ff != cons;
         end
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
      fin_ff <= fin_in;
      if (reset) begin
         fill_ff <= 3'd0;
         busy_ff <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         busy_ff <= busy_in;
      end
   end

endmodule

[rtl/core/utf8gs_queue.sv]
module utf8gs_queue
   import utf8gs_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  logic           clock,
   input  logic           reset,
   input  queue_port_type push,
   output logic           full,
   output queue_port_type head,
   input  logic           pop
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type        mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push, do_pop;

   assign full       = count_ff == CNT_W'(DEPTH);
   assign head.valid = count_ff != '0;
   assign head.entry = mem_ff[rd_ptr_ff];
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && head.valid;

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push.entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

[rtl/core/utf8gs_back.sv]
module utf8gs_back
   import utf8gs_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  queue_port_type head,
   output logic           pop,
   utf8gs_if.source       rsp_bus
);

   logic [20:0]      held_value_ff, held_value_in;
   logic [2:0]       held_length_ff, held_length_in;
   held_flags_type   held_flags_ff, held_flags_in;
   cluster_mode_type cluster_mode_ff, cluster_mode_in;
   logic             joiner_waiting_ff, joiner_waiting_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_payload_type  rsp_data_ff, rsp_data_in;

   logic held_full, out_free, fire, load, out_last, out_end;
   logic starts, cur_ri, cur_ext, cur_joiner;

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.data  = rsp_data_ff;

   assign held_full = held_length_ff != 3'd0;
   assign out_free  = !rsp_valid_ff || rsp_bus.ready;

   // a held codepoint leaves once it is known whether more of its request follow
   always_comb begin
      pop      = 1'b0;
      fire     = 1'b0;
      load     = 1'b0;
      out_last = 1'b0;
      out_end  = 1'b0;
      if (held_full && held_flags_ff.step_end) begin
         if (out_free) begin
            fire     = 1'b1;
            out_last = 1'b1;
            out_end  = held_flags_ff.text_fin;
         end
      end else if (head.valid) begin
         if (head.entry.has_result) begin
            if (!held_full || out_free) begin
               pop  = 1'b1;
               load = 1'b1;
               fire = held_full;
            end
         end else if (!held_full) begin
            pop = 1'b1;
         end else if (out_free) begin
            pop      = 1'b1;
            fire     = 1'b1;
            out_last = 1'b1;
            out_end  = head.entry.text_fin;
         end
      end
   end

   always_comb begin
      held_value_in  = held_value_ff;
      held_length_in = held_length_ff;
      held_flags_in  = held_flags_ff;
      if (load) begin
         held_value_in           = head.entry.code_value;
         held_length_in          = head.entry.byte_count;
         held_flags_in.replaced  = head.entry.replaced;
         held_flags_in.step_end  = head.entry.step_end;
         held_flags_in.text_fin  = head.entry.text_fin;
      end else if (fire) begin
         held_length_in = 3'd0;
         held_flags_in  = '0;
      end
   end

   always_comb begin
      cur_ri     = is_ri(held_value_ff);
      cur_ext    = is_extend(held_value_ff);
      cur_joiner = held_value_ff == JOINER;
   end

   // character boundary decision
   always_comb begin
      starts = 1'b1;
      if (cluster_mode_ff == MODE_RI_OPEN && cur_ri) begin
         starts = 1'b0;
      end else if (cluster_mode_ff == MODE_NORMAL) begin
         if (joiner_waiting_ff || cur_ext || (cur_joiner && !out_end)) starts = 1'b0;
      end
   end

   // segmentation state update
   always_comb begin
      cluster_mode_in   = cluster_mode_ff;
      joiner_waiting_in = joiner_waiting_ff;
      if (fire) begin
         if (out_end) begin
            cluster_mode_in   = MODE_START;
            joiner_waiting_in = 1'b0;
         end else if (cluster_mode_ff == MODE_RI_OPEN && cur_ri) begin
            cluster_mode_in = MODE_CLOSED;
         end else if (starts) begin
            joiner_waiting_in = 1'b0;
            cluster_mode_in   = cur_ri ? MODE_RI_OPEN : MODE_NORMAL;
         end else if (joiner_waiting_ff) begin
            joiner_waiting_in = 1'b0;
         end else if (!cur_ext && cur_joiner) begin
            joiner_waiting_in = 1'b1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (fire) begin
         rsp_valid_in                 = 1'b1;
         rsp_data_in.code_value       = held_value_ff;
         rsp_data_in.byte_count       = held_length_ff;
         rsp_data_in.replaced         = held_flags_ff.replaced;
         rsp_data_in.starts_character = starts;
         rsp_data_in.text_end         = out_end;
         rsp_data_in.run_last         = out_last;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         held_value_ff     <= '0;
         held_length_ff    <= 3'd0;
         held_flags_ff     <= '0;
         cluster_mode_ff   <= MODE_START;
         joiner_waiting_ff <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         held_value_ff     <= held_value_in;
         held_length_ff    <= held_length_in;
         held_flags_ff     <= held_flags_in;
         cluster_mode_ff   <= cluster_mode_in;
         joiner_waiting_ff <= joiner_waiting_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

endmodule
